// File: src/byte_range_lock_table_unit_assert.svh
// Assertion macros for the byte-range lock table.
`ifndef BYTE_RANGE_LOCK_TABLE_UNIT_ASSERT_SVH
`define BYTE_RANGE_LOCK_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BRLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define BRLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/brlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlt_pkg
// Types and codes shared by the byte-range lock table.
// ----------------------------------------------------------------------------
package brlt_pkg;

  localparam int OFF_W = 63;
  localparam logic [OFF_W-1:0] OFF_LIMIT = {OFF_W{1'b1}};

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_UNLOCK = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_PURGE  = 2'd3
  } brlt_action_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_CONFLICT = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_RSVD     = 2'd3
  } brlt_status_t;

  localparam logic [1:0] CT_NONE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_DRAIN = 2'd2,
    S_WB    = 2'd3
  } brlt_state_t;

endpackage

// File: src/byte_range_lock_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_range_lock_table_unit
// Bounded table of advisory byte-range locks: set, unlock, query, purge.
// ----------------------------------------------------------------------------
// Usage:
//   Drive a request on the in_ ports and raise start; it is taken at a rising
//   edge with busy low. Each request gives exactly one result, shown on the
//   out_ ports for one cycle with out_valid high. The receiver cannot stall.
// Timing:
//   A request reads the entry RAM one entry per cycle, then a drain state
//   evaluates the last read and a write-back state updates the table. The
//   result appears the cycle after write-back, and a new request may be taken
//   in that same cycle.
//   The scan over the single RAM read port sets the rate.
// Reset:
//   rst_n low clears all valid bits and returns to idle; no clearing pass
//   is needed since entry data is used only when valid.
// Results:
//   status 0 done, 1 conflict, 2 table full. Without a conflict to report,
//   conflict_type is 2 and the other conflict fields are zero.
// ----------------------------------------------------------------------------
module byte_range_lock_table_unit #(
  parameter int LOCK_ENTRIES = 16,
  parameter int OWNER_BITS   = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_action,
  input  logic [15:0]               in_owner,
  input  logic                      in_lock_type,
  input  logic [brlt_pkg::OFF_W-1:0] in_range_start,
  input  logic [brlt_pkg::OFF_W-1:0] in_range_length,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [1:0]                out_conflict_type,
  output logic [brlt_pkg::OFF_W-1:0] out_conflict_start,
  output logic [brlt_pkg::OFF_W-1:0] out_conflict_length,
  output logic [15:0]               out_conflict_owner
);
  import brlt_pkg::*;

  localparam int OW = (OWNER_BITS < 16) ? OWNER_BITS : 16;
  localparam int IW = $clog2(LOCK_ENTRIES);
  localparam int DW = OW + 1 + 2 * OFF_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(LOCK_ENTRIES - 1);

  // inclusive end offset, saturated at the offset limit
  function automatic logic [OFF_W-1:0] range_end(input logic [OFF_W-1:0] s,
                                                 input logic [OFF_W-1:0] l);
    logic [OFF_W:0] sum;
    sum = {1'b0, s} + {1'b0, l} - (OFF_W+1)'(1);
    if (l == '0 || sum[OFF_W]) begin
      return OFF_LIMIT;
    end
    return sum[OFF_W-1:0];
  endfunction

  brlt_state_t state_r, state_nxt;

  // latched request
  brlt_action_t       act_r;
  logic [OW-1:0]      own_r;
  logic               kind_r;
  logic [OFF_W-1:0]   rs_r, rl_r, re_r;

  // scan control
  logic [IW-1:0] cnt_r;
  logic          eval_en_r;
  logic [IW-1:0] eval_idx_r;

  // table state in flops
  logic            valid_r [LOCK_ENTRIES];
  logic [IW-1:0]   age_r   [LOCK_ENTRIES];

  // scan results
  logic            best_f_r;
  logic [IW-1:0]   best_idx_r;
  logic [IW-1:0]   best_age_r;
  logic            free_f_r;
  logic [IW-1:0]   free_idx_r;
  logic [OW-1:0]   hit_own_r;
  logic            hit_kind_r;
  logic [OFF_W-1:0] hit_s_r, hit_l_r;

  // RAM interface
  logic          ram_we;
  logic [DW-1:0] ram_wdata, ram_rdata;
  logic [IW-1:0] ram_raddr;

  // entry fields of the current read
  logic [OW-1:0]    e_own;
  logic             e_kind;
  logic [OFF_W-1:0] e_s, e_l, e_end;
  logic             e_valid;
  logic [IW-1:0]    e_age;
  logic             own_eq, clash, match, better;

  // table update controls
  logic          drop_en, ins_en;
  logic [IW-1:0] drop_idx, drop_age;

  // output registers
  logic             out_valid_r;
  logic [1:0]       out_status_r, out_ctype_r;
  logic [OFF_W-1:0] out_s_r, out_l_r;
  logic [15:0]      out_own_r;

  logic accept;
  assign accept = start && !busy;

  brlt_ram #(.WIDTH(DW), .DEPTH(LOCK_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SCAN;
      S_SCAN:  if (cnt_r == LAST_IDX) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_WB;
      S_WB:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy      = (state_r != S_IDLE);
    ram_raddr = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // latch request
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= brlt_action_t'(in_action);
      own_r  <= OW'(in_owner);
      kind_r <= in_lock_type;
      rs_r   <= in_range_start;
      rl_r   <= in_range_length;
      re_r   <= range_end(in_range_start, in_range_length);
    end
  end

  // advance scan index and read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      eval_en_r <= 1'b0;
    end else begin
      eval_en_r <= (state_r == S_SCAN);
      if (state_r == S_SCAN) begin
        cnt_r <= (cnt_r == LAST_IDX) ? '0 : cnt_r + IW'(1);
      end else begin
        cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= cnt_r;
  end

  // evaluate the entry that was read last cycle
  always_comb begin
    {e_own, e_kind, e_s, e_l} = ram_rdata;
    e_end   = range_end(e_s, e_l);
    e_valid = valid_r[eval_idx_r];
    e_age   = age_r[eval_idx_r];
    own_eq  = (e_own == own_r);
    clash   = e_valid && !own_eq && (e_kind || kind_r) && !(e_s > re_r) && !(rs_r > e_end);
    match   = e_valid && own_eq && (e_s == rs_r) && (e_l == rl_r);
    better  = !best_f_r || (e_age < best_age_r);
  end

  // track newest hit and first free slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_f_r <= 1'b0;
      free_f_r <= 1'b0;
    end else if (accept) begin
      best_f_r <= 1'b0;
      free_f_r <= 1'b0;
    end else if (eval_en_r) begin
      if (!e_valid && !free_f_r) begin
        free_f_r <= 1'b1;
      end
      if (((act_r == ACT_SET || act_r == ACT_QUERY) && clash) ||
          (act_r == ACT_UNLOCK && match)) begin
        if (better) begin
          best_f_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval_en_r) begin
      if (!e_valid && !free_f_r) begin
        free_idx_r <= eval_idx_r;
      end
      if ((((act_r == ACT_SET || act_r == ACT_QUERY) && clash) ||
           (act_r == ACT_UNLOCK && match)) && better) begin
        best_idx_r <= eval_idx_r;
        best_age_r <= e_age;
        hit_own_r  <= e_own;
        hit_kind_r <= e_kind;
        hit_s_r    <= e_s;
        hit_l_r    <= e_l;
      end
    end
  end

  // drop and insert decisions
  always_comb begin
    drop_en  = 1'b0;
    drop_idx = eval_idx_r;
    drop_age = e_age;
    ins_en   = 1'b0;
    if (eval_en_r && act_r == ACT_PURGE && e_valid && own_eq) begin
      drop_en = 1'b1;
    end else if (state_r == S_WB && act_r == ACT_UNLOCK && best_f_r) begin
      drop_en  = 1'b1;
      drop_idx = best_idx_r;
      drop_age = best_age_r;
    end
    if (state_r == S_WB && act_r == ACT_SET && !best_f_r && free_f_r) begin
      ins_en = 1'b1;
    end
    ram_we    = ins_en;
    ram_wdata = {own_r, kind_r, rs_r, rl_r};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < LOCK_ENTRIES; j++) begin
        valid_r[j] <= 1'b0;
      end
    end else if (drop_en) begin
      valid_r[drop_idx] <= 1'b0;
    end else if (ins_en) begin
      valid_r[free_idx_r] <= 1'b1;
    end
  end

  // ages: shift ranks on drop and insert
  always_ff @(posedge clk) begin
    if (drop_en) begin
      for (int j = 0; j < LOCK_ENTRIES; j++) begin
        if (valid_r[j] && age_r[j] > drop_age) begin
          age_r[j] <= age_r[j] - IW'(1);
        end
      end
    end else if (ins_en) begin
      for (int j = 0; j < LOCK_ENTRIES; j++) begin
        if (valid_r[j]) begin
          age_r[j] <= age_r[j] + IW'(1);
        end
      end
      age_r[free_idx_r] <= '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_WB);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WB) begin
      if ((act_r == ACT_SET || act_r == ACT_QUERY) && best_f_r) begin
        out_status_r <= STAT_CONFLICT;
        out_ctype_r  <= {1'b0, hit_kind_r};
        out_s_r      <= hit_s_r;
        out_l_r      <= hit_l_r;
        out_own_r    <= 16'(hit_own_r);
      end else begin
        out_status_r <= (act_r == ACT_SET && !free_f_r) ? STAT_FULL : STAT_DONE;
        out_ctype_r  <= CT_NONE;
        out_s_r      <= '0;
        out_l_r      <= '0;
        out_own_r    <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_conflict_type   = out_ctype_r;
  assign out_conflict_start  = out_s_r;
  assign out_conflict_length = out_l_r;
  assign out_conflict_owner  = out_own_r;

`include "byte_range_lock_table_unit_assert.svh"

  `BRLT_ASSERT_NEXT(a_busy_after_accept, accept, busy, "request accepted but block not busy")
  `BRLT_ASSERT_NOW(a_result_after_wb, out_valid, $past(state_r) == S_WB, "result without write-back")
  `BRLT_ASSERT_NOW(a_conflict_reported, out_valid && out_status == STAT_CONFLICT, out_conflict_type != CT_NONE, "conflict without entry")
  `BRLT_ASSERT_NOW(a_no_insert_with_hit, ins_en, !best_f_r && free_f_r, "insert despite conflict or full table")

endmodule

// File: src/brlt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brlt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module brlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
